@@ src/gbn_pkg.sv @@
// Go-Back-N sender window: shared types and constants.
// Request and response structs, operation and result codes, register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

  localparam int unsigned WINDOW_MAX  = 32;
  localparam int unsigned MAX_RESULTS = 32;

  localparam logic [5:0]  WINDOW_SIZE_RESET   = 6'd4;
  localparam logic [15:0] PACKET_TOTAL_RESET  = 16'd0;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd200;

  typedef enum logic [1:0] {
    CfgWindowSize   = 2'd0,
    CfgPacketTotal  = 2'd1,
    CfgTimeoutTicks = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    OpSend = 2'd0,
    OpAck  = 2'd1,
    OpTick = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KindSent     = 3'd0,
    KindFull     = 3'd1,
    KindAllSent  = 3'd2,
    KindNewAck   = 3'd3,
    KindDupAck   = 3'd4,
    KindResend   = 3'd5,
    KindComplete = 3'd6
  } kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic        ack_flag;
    logic [15:0] ack_number;
  } req_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [15:0] seq_number;
    logic [15:0] window_base;
    logic        last;
  } rsp_t;

endpackage

`default_nettype wire

@@ src/go_back_n_sender_window.sv @@
// Go-Back-N sender window control, top level.
// Keeps per-sequence send timestamps in a one-port-write, one-port-read memory.
// Depends on gbn_pkg.
//
// Usage: each request on req_i (valid/ready) is one of send, ack or tick.
// Send and ack requests yield exactly one response on rsp_o; a tick yields
// none, or, if a duplicate ack armed it and the base timestamp expired, one
// resend per outstanding sequence (up to 32), last set on the final one.
// Flow: a request is registered in req_q from StIdle, and StDecide then
// loads its response into the response register. A tick that resends goes
// on to StResend, where the timestamp memory write port restamps one
// sequence per cycle while the response register is free.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) land at once
// and are meant for idle periods only.
// Reset clears the window, the tick counter and the flags and loads the
// register defaults; the timestamp memory needs no clearing.
// A stalled receiver holds the response register; the block keeps one
// request in flight and waits, taking nothing new until it moves on.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_window #(
  parameter int unsigned WindowMax = gbn_pkg::WINDOW_MAX
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire gbn_pkg::req_t req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output gbn_pkg::rsp_t      rsp_o,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [15:0]   cfg_wdata_i
);

  import gbn_pkg::*;

  localparam int unsigned AW    = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int unsigned Depth = 2 ** AW;
  localparam int unsigned EW    = $clog2(WindowMax + 1);
  localparam int unsigned RW    = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    StIdle,
    StDecide,
    StResend
  } state_e;

  state_e      state_q;
  req_t        req_q;
  rsp_t        out_q;
  logic        out_valid_q;
  logic [5:0]  window_size_q;
  logic [15:0] packet_total_q;
  logic [15:0] timeout_ticks_q;
  logic [15:0] base_q;
  logic [15:0] next_q;
  logic        armed_q;
  logic        done_q;
  logic [31:0] tick_q;
  logic [15:0] cur_q;
  logic [RW-1:0] rem_q;

  logic [31:0] mem [Depth];
  logic [31:0] rdata_q;

  logic          accept;
  logic          out_free;
  logic          out_load;
  logic [EW-1:0] eff_win;
  logic [15:0]   diff;
  logic          all_sent;
  logic          win_full;
  logic [15:0]   capped;
  logic          ack_adv;
  logic [16:0]   cnt_full;
  logic [RW-1:0] cnt;
  logic [31:0]   elapsed;
  logic          resend_go;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  always_comb begin
    if (window_size_q == 6'd0) begin
      eff_win = EW'(1);
    end else if (17'(window_size_q) > 17'(WindowMax)) begin
      eff_win = EW'(WindowMax);
    end else begin
      eff_win = EW'(window_size_q);
    end
    diff     = next_q - base_q;
    all_sent = (next_q >= packet_total_q);
    win_full = (17'(diff) >= 17'(eff_win));
    capped   = (req_q.ack_number < next_q) ? req_q.ack_number : next_q;
    ack_adv  = req_q.ack_flag && (capped > base_q);

    cnt_full = 17'(diff);
    if (17'(eff_win) < cnt_full) begin
      cnt_full = 17'(eff_win);
    end
    if (packet_total_q <= base_q) begin
      cnt_full = 17'd0;
    end else if (17'(packet_total_q - base_q) < cnt_full) begin
      cnt_full = 17'(packet_total_q - base_q);
    end
    if (cnt_full > 17'(MAX_RESULTS)) begin
      cnt_full = 17'(MAX_RESULTS);
    end
    cnt = cnt_full[RW-1:0];

    elapsed   = tick_q - rdata_q;
    resend_go = armed_q && !done_q && (base_q < next_q)
                && (elapsed > 32'(timeout_ticks_q)) && (cnt != '0);

    mem_we    = 1'b0;
    mem_waddr = next_q[AW-1:0];
    out_load  = 1'b0;
    case (state_q)
      StDecide: begin
        if (req_q.operation == OpSend && out_free && !all_sent && !win_full) begin
          mem_we = 1'b1;
        end
        if ((req_q.operation == OpSend || req_q.operation == OpAck) && out_free) begin
          out_load = 1'b1;
        end
      end
      StResend: begin
        mem_we    = out_free;
        mem_waddr = cur_q[AW-1:0];
        out_load  = out_free;
      end
      default: begin
        mem_we   = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= tick_q;
    end
    if (accept) begin
      rdata_q <= mem[base_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      req_q           <= '0;
      out_q           <= '0;
      out_valid_q     <= 1'b0;
      window_size_q   <= WINDOW_SIZE_RESET;
      packet_total_q  <= PACKET_TOTAL_RESET;
      timeout_ticks_q <= TIMEOUT_TICKS_RESET;
      base_q          <= '0;
      next_q          <= '0;
      armed_q         <= 1'b0;
      done_q          <= 1'b0;
      tick_q          <= '0;
      cur_q           <= '0;
      rem_q           <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgWindowSize:   window_size_q   <= cfg_wdata_i[5:0];
          CfgPacketTotal:  packet_total_q  <= cfg_wdata_i;
          CfgTimeoutTicks: timeout_ticks_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            req_q <= req_i;
            if (req_i.operation == OpTick) begin
              tick_q <= tick_q + 32'd1;
            end
            state_q <= StDecide;
          end
        end
        StDecide: begin
          case (req_q.operation)
            OpSend: begin
              if (out_free) begin
                out_q.window_base <= base_q;
                out_q.last        <= 1'b1;
                if (all_sent) begin
                  out_q.result_kind <= KindAllSent;
                  out_q.seq_number  <= '0;
                end else if (win_full) begin
                  out_q.result_kind <= KindFull;
                  out_q.seq_number  <= '0;
                end else begin
                  out_q.result_kind <= KindSent;
                  out_q.seq_number  <= next_q;
                  next_q            <= next_q + 16'd1;
                end
                state_q <= StIdle;
              end
            end
            OpAck: begin
              if (out_free) begin
                out_q.last       <= 1'b1;
                out_q.seq_number <= '0;
                if (ack_adv) begin
                  base_q            <= capped;
                  armed_q           <= 1'b0;
                  out_q.window_base <= capped;
                  if (capped >= packet_total_q) begin
                    done_q            <= 1'b1;
                    out_q.result_kind <= KindComplete;
                  end else begin
                    out_q.result_kind <= KindNewAck;
                  end
                end else begin
                  armed_q           <= 1'b1;
                  out_q.window_base <= base_q;
                  out_q.result_kind <= KindDupAck;
                end
                state_q <= StIdle;
              end
            end
            OpTick: begin
              if (resend_go) begin
                cur_q   <= base_q;
                rem_q   <= cnt;
                state_q <= StResend;
              end else begin
                state_q <= StIdle;
              end
            end
            default: begin
              state_q <= StIdle;
            end
          endcase
        end
        StResend: begin
          if (out_free) begin
            out_q.result_kind <= KindResend;
            out_q.seq_number  <= cur_q;
            out_q.window_base <= base_q;
            out_q.last        <= (rem_q == RW'(1));
            cur_q             <= cur_q + 16'd1;
            rem_q             <= rem_q - RW'(1);
            if (rem_q == RW'(1)) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
